// ===== rtl/qrv_pkg.sv =====
// Shared widths, payload types and limits for the quaternion rotation block.
`default_nettype none

package qrv_pkg;

    localparam int unsigned D_W     = 32;          // input and output component width
    localparam int unsigned SQ_W    = 2 * D_W;     // 32 x 32 product
    localparam int unsigned M_W     = SQ_W + 2;    // sum of four squares
    localparam int unsigned OP_W    = SQ_W + 3;    // wide operand: w^2 - |r|^2, r.v, r x v
    localparam int unsigned PH_W    = OP_W - D_W;  // signed upper slice of a wide operand
    localparam int unsigned PP_HI_W = PH_W + D_W;
    localparam int unsigned PP_LO_W = D_W + 1 + D_W;
    localparam int unsigned TERM_W  = OP_W + D_W;
    localparam int unsigned N_W     = TERM_W + 1;  // numerator before rounding
    localparam int unsigned NUM_W   = N_W + 1;     // 2|N| + M
    localparam int unsigned DEN_W   = M_W + 1;     // 2M
    localparam int unsigned Q_W     = D_W;         // quotient bits kept
    localparam int unsigned LANES   = 3;
    localparam int unsigned TERMS   = 3;

    localparam logic [D_W-1:0] POS_LIMIT = {1'b0, {(D_W-1){1'b1}}};
    localparam logic [D_W-1:0] NEG_LIMIT = {1'b1, {(D_W-1){1'b0}}};

    typedef struct packed {
        logic signed [D_W-1:0] vec_x;
        logic signed [D_W-1:0] vec_y;
        logic signed [D_W-1:0] vec_z;
        logic signed [D_W-1:0] rot_x;
        logic signed [D_W-1:0] rot_y;
        logic signed [D_W-1:0] rot_z;
        logic signed [D_W-1:0] rot_w;
    } qrv_in_t;

    typedef struct packed {
        logic signed [D_W-1:0] out_x;
        logic signed [D_W-1:0] out_y;
        logic signed [D_W-1:0] out_z;
        logic                  zero_rotation;
        logic                  saturated;
    } qrv_out_t;

    typedef struct packed {
        qrv_in_t data;
        logic    zero;
    } qrv_item_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
    } qrv_div_t;

endpackage

`default_nettype wire

// ===== rtl/qrv_if.sv =====
// Valid/ready channel carrying one payload per request.
`default_nettype none

interface qrv_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/quaternion_rotate_vector.sv =====
// A request passes from acceptance to result valid through the input queue, the product
// pipeline and the divider (entry check, one quotient bit per stage for 32 stages, then clip
// into the output register). Throughput: one request per cycle while the result is not
// stalled; the divider pipeline takes one bit per stage, so a new division enters every cycle
// unless the output stalls. Reset clears all valid state and the queue.
`default_nettype none

module quaternion_rotate_vector
    import qrv_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qrv_if.sink        request,
    qrv_if.source      result
);

    // Front: accept and classify, then queue; the input waits only while the queue is full.
    logic                  head_valid;
    qrv_item_t             head;
    logic                  adv;

    // Back: exact numerator and divisor, then one rounding division per component.
    logic                  dp_valid;
    qrv_div_t [LANES-1:0]  dp_job;
    logic [DEN_W-1:0]      dp_den;
    logic                  dp_zero;

    // Advance the whole back end unless a finished result is still waiting.
    assign adv = !result.valid || result.ready;

    qrv_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .pop        (adv),
        .head_valid (head_valid),
        .head       (head)
    );

    qrv_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (head_valid),
        .in_item   (head),
        .out_valid (dp_valid),
        .out_job   (dp_job),
        .out_den   (dp_den),
        .out_zero  (dp_zero)
    );

    qrv_divider u_divider (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (dp_valid),
        .in_job     (dp_job),
        .in_den     (dp_den),
        .in_zero    (dp_zero),
        .out_valid  (result.valid),
        .out_result (result.data)
    );

endmodule

`default_nettype wire

// ===== rtl/qrv_front.sv =====
// Front end: accept requests, flag zero quaternions, hold them in a short queue.
`default_nettype none

module qrv_front
    import qrv_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qrv_if.sink        request,
    input  wire logic  pop,
    output logic       head_valid,
    output qrv_item_t  head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    qrv_item_t          queue_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    logic               take;
    qrv_item_t          incoming;

    assign request.ready = (count_reg != CNT_W'(DEPTH));
    assign push          = request.valid && request.ready;
    assign head_valid    = (count_reg != '0);
    assign take          = pop && head_valid;
    assign head          = queue_reg[rd_ptr_reg];

    always_comb
    begin
        incoming.data = request.data;
        incoming.zero = (request.data.rot_x == '0) && (request.data.rot_y == '0) &&
                        (request.data.rot_z == '0) && (request.data.rot_w == '0);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (take)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/qrv_datapath.sv =====
// Product pipeline: squares, dot and cross products, exact numerator and divisor.
`default_nettype none

module qrv_datapath
    import qrv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire qrv_item_t             in_item,
    output logic                       out_valid,
    output qrv_div_t [LANES-1:0]       out_job,
    output logic [DEN_W-1:0]           out_den,
    output logic                       out_zero
);

    localparam int unsigned STAGES = 7;

    logic [STAGES-1:0]          vld_reg;
    logic [STAGES-1:0]          zero_reg;

    logic signed [D_W-1:0]      v_in [LANES];
    logic signed [D_W-1:0]      r_in [LANES];

    // stage 1
    logic signed [SQ_W-1:0]     sqw1_reg, sqr1_reg [LANES];
    logic signed [SQ_W-1:0]     rv1_reg [LANES][LANES];
    logic signed [D_W-1:0]      v1_reg [LANES], r1_reg [LANES], w1_reg;
    // stage 2
    logic [M_W-1:0]             m2_reg;
    logic signed [OP_W-1:0]     s2_reg, d2_reg, c2_reg [LANES];
    logic signed [D_W-1:0]      v2_reg [LANES], r2_reg [LANES], w2_reg;
    // stage 3
    logic signed [OP_W-1:0]     opa [LANES][TERMS];
    logic signed [D_W-1:0]      opb [LANES][TERMS];
    logic signed [PP_HI_W-1:0]  hi3_reg [LANES][TERMS];
    logic signed [PP_LO_W-1:0]  lo3_reg [LANES][TERMS];
    logic [M_W-1:0]             m3_reg;
    // stage 4
    logic signed [TERM_W-1:0]   t4_reg [LANES][TERMS];
    logic [M_W-1:0]             m4_reg;
    // stage 5
    logic signed [N_W-1:0]      n5_reg [LANES];
    logic [M_W-1:0]             m5_reg;
    // stage 6
    logic [N_W-1:0]             mag6_reg [LANES];
    logic                       neg6_reg [LANES];
    logic [M_W-1:0]             m6_reg;
    // stage 7
    qrv_div_t [LANES-1:0]       job7_reg;
    logic [DEN_W-1:0]           den7_reg;

    always_comb
    begin
        v_in[0] = in_item.data.vec_x;
        v_in[1] = in_item.data.vec_y;
        v_in[2] = in_item.data.vec_z;
        r_in[0] = in_item.data.rot_x;
        r_in[1] = in_item.data.rot_y;
        r_in[2] = in_item.data.rot_z;
    end

    // Term k of lane l: (w^2-|r|^2) v_l, (r.v) r_l, w (r x v)_l.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            opa[l][0] = s2_reg;
            opb[l][0] = v2_reg[l];
            opa[l][1] = d2_reg;
            opb[l][1] = r2_reg[l];
            opa[l][2] = c2_reg[l];
            opb[l][2] = w2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg <= {zero_reg[STAGES-2:0], in_item.zero};

            sqw1_reg <= in_item.data.rot_w * in_item.data.rot_w;
            w1_reg   <= in_item.data.rot_w;
            for (int i = 0; i < LANES; i++)
            begin
                sqr1_reg[i] <= r_in[i] * r_in[i];
                v1_reg[i]   <= v_in[i];
                r1_reg[i]   <= r_in[i];
                for (int j = 0; j < LANES; j++)
                begin
                    rv1_reg[i][j] <= r_in[i] * v_in[j];
                end
            end

            m2_reg <= M_W'($unsigned(sqw1_reg)) + M_W'($unsigned(sqr1_reg[0])) +
                      M_W'($unsigned(sqr1_reg[1])) + M_W'($unsigned(sqr1_reg[2]));
            s2_reg <= OP_W'(sqw1_reg) - OP_W'(sqr1_reg[0]) - OP_W'(sqr1_reg[1]) -
                      OP_W'(sqr1_reg[2]);
            d2_reg <= OP_W'(rv1_reg[0][0]) + OP_W'(rv1_reg[1][1]) + OP_W'(rv1_reg[2][2]);
            c2_reg[0] <= OP_W'(rv1_reg[1][2]) - OP_W'(rv1_reg[2][1]);
            c2_reg[1] <= OP_W'(rv1_reg[2][0]) - OP_W'(rv1_reg[0][2]);
            c2_reg[2] <= OP_W'(rv1_reg[0][1]) - OP_W'(rv1_reg[1][0]);
            v2_reg <= v1_reg;
            r2_reg <= r1_reg;
            w2_reg <= w1_reg;

            // Split each wide operand into a signed upper and unsigned lower slice.
            for (int l = 0; l < LANES; l++)
            begin
                for (int t = 0; t < TERMS; t++)
                begin
                    hi3_reg[l][t] <= $signed(opa[l][t][OP_W-1:D_W]) * opb[l][t];
                    lo3_reg[l][t] <= $signed({1'b0, opa[l][t][D_W-1:0]}) * opb[l][t];
                end
            end
            m3_reg <= m2_reg;

            for (int l = 0; l < LANES; l++)
            begin
                for (int t = 0; t < TERMS; t++)
                begin
                    t4_reg[l][t] <= (TERM_W'(hi3_reg[l][t]) <<< D_W) + TERM_W'(lo3_reg[l][t]);
                end
            end
            m4_reg <= m3_reg;

            for (int l = 0; l < LANES; l++)
            begin
                n5_reg[l] <= N_W'(t4_reg[l][0]) + (N_W'(t4_reg[l][1]) <<< 1) +
                             (N_W'(t4_reg[l][2]) <<< 1);
            end
            m5_reg <= m4_reg;

            for (int l = 0; l < LANES; l++)
            begin
                neg6_reg[l] <= n5_reg[l][N_W-1];
                mag6_reg[l] <= n5_reg[l][N_W-1] ? N_W'(-n5_reg[l]) : N_W'(n5_reg[l]);
            end
            m6_reg <= m5_reg;

            // Round to nearest: (2|N| + M) / 2M.
            for (int l = 0; l < LANES; l++)
            begin
                job7_reg[l].num <= {mag6_reg[l], 1'b0} + NUM_W'(m6_reg);
                job7_reg[l].neg <= neg6_reg[l];
            end
            den7_reg <= {m6_reg, 1'b0};
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_zero  = zero_reg[STAGES-1];
    assign out_job   = job7_reg;
    assign out_den   = den7_reg;

endmodule

`default_nettype wire

// ===== rtl/qrv_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with rounding and clipping.
`default_nettype none

module qrv_divider
    import qrv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  adv,
    input  wire logic                  in_valid,
    input  wire qrv_div_t [LANES-1:0]  in_job,
    input  wire logic [DEN_W-1:0]      in_den,
    input  wire logic                  in_zero,
    output logic                       out_valid,
    output qrv_out_t                   out_result
);

    localparam int unsigned VLD_W = Q_W + 2;

    logic [VLD_W-1:0]   vld_reg;
    logic [NUM_W-1:0]   rem_reg  [Q_W+1][LANES];
    logic [Q_W-1:0]     quo_reg  [Q_W+1][LANES];
    logic               neg_reg  [Q_W+1][LANES];
    logic               ovf_reg  [Q_W+1][LANES];
    logic [DEN_W-1:0]   den_reg  [Q_W+1];
    logic               zero_reg [Q_W+1];

    logic [NUM_W-1:0]   trial    [Q_W][LANES];
    logic               fits     [Q_W][LANES];
    logic [NUM_W-1:0]   diff     [Q_W][LANES];

    logic [D_W-1:0]     lane_val [LANES];
    logic               lane_sat [LANES];
    qrv_out_t           result_next;
    qrv_out_t           result_reg;

    always_comb
    begin
        for (int s = 0; s < Q_W; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[s][l] = NUM_W'(den_reg[s]) << (Q_W - 1 - s);
                fits[s][l]  = (rem_reg[s][l] >= trial[s][l]);
                diff[s][l]  = rem_reg[s][l] - trial[s][l];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            lane_sat[l] = ovf_reg[Q_W][l] ||
                          (quo_reg[Q_W][l] > (neg_reg[Q_W][l] ? NEG_LIMIT : POS_LIMIT));
            if (lane_sat[l])
            begin
                lane_val[l] = neg_reg[Q_W][l] ? NEG_LIMIT : POS_LIMIT;
            end
            else
            begin
                lane_val[l] = neg_reg[Q_W][l] ? -quo_reg[Q_W][l] : quo_reg[Q_W][l];
            end
        end
        if (zero_reg[Q_W])
        begin
            result_next = '0;
            result_next.zero_rotation = 1'b1;
        end
        else
        begin
            result_next.out_x         = lane_val[0];
            result_next.out_y         = lane_val[1];
            result_next.out_z         = lane_val[2];
            result_next.zero_rotation = 1'b0;
            result_next.saturated     = lane_sat[0] || lane_sat[1] || lane_sat[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[VLD_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Entry: flag quotients that cannot fit in Q_W bits.
            den_reg[0]  <= in_den;
            zero_reg[0] <= in_zero;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= in_job[l].num;
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= in_job[l].neg;
                ovf_reg[0][l] <= (in_job[l].num >= (NUM_W'(in_den) << Q_W));
            end

            for (int s = 0; s < Q_W; s++)
            begin
                den_reg[s+1]  <= den_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s+1][l] <= fits[s][l] ? diff[s][l] : rem_reg[s][l];
                    quo_reg[s+1][l] <= {quo_reg[s][l][Q_W-2:0], fits[s][l]};
                    neg_reg[s+1][l] <= neg_reg[s][l];
                    ovf_reg[s+1][l] <= ovf_reg[s][l];
                end
            end

            result_reg <= result_next;
        end
    end

    assign out_valid  = vld_reg[VLD_W-1];
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/qrv_checker.sv =====
// Port-level checks for the quaternion rotation block, bound to its top level.
`default_nettype none

module qrv_checker
    import qrv_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      res_valid,
    input wire logic      res_ready,
    input wire qrv_out_t  res_data
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_data))
        else $error("result changed while stalled");

    a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zero_rotation |->
            res_data.out_x == '0 && res_data.out_y == '0 && res_data.out_z == '0 &&
            !res_data.saturated)
        else $error("zero rotation with nonzero result");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.saturated |->
            res_data.out_x == POS_LIMIT || res_data.out_x == NEG_LIMIT ||
            res_data.out_y == POS_LIMIT || res_data.out_y == NEG_LIMIT ||
            res_data.out_z == POS_LIMIT || res_data.out_z == NEG_LIMIT)
        else $error("saturated flag with no clipped component");

endmodule

bind quaternion_rotate_vector qrv_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_data  (result.data)
);

`default_nettype wire

// ===== tb/quaternion_rotate_vector_tb.sv =====
// Testbench for quaternion_rotate_vector: exact predictor, handshake driver and monitor.
`default_nettype none

module quaternion_rotate_vector_tb;
    import qrv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LATENCY   = 42;
    localparam int unsigned MAX_CYCLE = 1_500_000;

    // idling phases
    typedef enum int {
        PH_FLOW,
        PH_SRC_IDLE,
        PH_DST_STALL,
        PH_BOTH
    } phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    qrv_if #(.payload_t(qrv_in_t))  req_ch ();
    qrv_if #(.payload_t(qrv_out_t)) res_ch ();

    quaternion_rotate_vector i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch.sink),
        .result  (res_ch.source)
    );

    qrv_in_t  pending_q[$];
    qrv_out_t rotated_q[$];
    phase_t   phase = PH_FLOW;
    bit       hold_src = 1'b0;
    bit       req_taken = 1'b0;
    int       mismatches = 0;
    longint   cycles = 0;

    // Round n / m to nearest, ties away from zero, then clip to 32 bits.
    function automatic logic signed [31:0] round_clip(logic signed [255:0] n,
                                                      logic signed [255:0] m,
                                                      ref bit sat);
        logic signed [255:0] mag;
        logic signed [255:0] q;
        logic signed [255:0] lim;
        bit                  neg;
        neg = n < 0;
        mag = neg ? -n : n;
        q   = (2 * mag + m) / (2 * m);
        lim = neg ? 256'sd2147483648 : 256'sd2147483647;
        if (q > lim)
        begin
            sat = 1'b1;
            q   = lim;
        end
        return neg ? -q[31:0] : q[31:0];
    endfunction

    // Vector part of q * v * conj(q) / |q|^2, formed exactly.
    function automatic qrv_out_t rotate(qrv_in_t a);
        logic signed [255:0] v[3];
        logic signed [255:0] r[3];
        logic signed [255:0] c[3];
        logic signed [255:0] w, m, s, d, n;
        qrv_out_t            o;
        bit                  sat;
        v[0] = a.vec_x; v[1] = a.vec_y; v[2] = a.vec_z;
        r[0] = a.rot_x; r[1] = a.rot_y; r[2] = a.rot_z;
        w    = a.rot_w;
        sat  = 1'b0;
        o    = '0;
        s    = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
        m    = w * w + s;
        if (m == 0)
        begin
            o.zero_rotation = 1'b1;
            return o;
        end
        s    = w * w - s;
        d    = r[0] * v[0] + r[1] * v[1] + r[2] * v[2];
        c[0] = r[1] * v[2] - r[2] * v[1];
        c[1] = r[2] * v[0] - r[0] * v[2];
        c[2] = r[0] * v[1] - r[1] * v[0];
        for (int k = 0; k < 3; k++)
        begin
            n = s * v[k] + 2 * d * r[k] + 2 * c[k] * w;
            case (k)
                0: o.out_x = round_clip(n, m, sat);
                1: o.out_y = round_clip(n, m, sat);
                default: o.out_z = round_clip(n, m, sat);
            endcase
        end
        o.saturated = sat;
        return o;
    endfunction

    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom;
            4: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            5: return 32'($signed($urandom_range(0, 8)) - 4);
            default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    function automatic qrv_in_t make_item(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                          logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                                          logic [31:0] rw);
        qrv_in_t t;
        t.vec_x = vx; t.vec_y = vy; t.vec_z = vz;
        t.rot_x = rx; t.rot_y = ry; t.rot_z = rz; t.rot_w = rw;
        return t;
    endfunction

    // Sender idles with probability 87/100 alone, 10/100 when both sides idle.
    function automatic bit src_pause();
        int roll;
        roll = int'($urandom_range(0, 99));
        case (phase)
            PH_SRC_IDLE: return roll < 87;
            PH_BOTH:     return roll < 10;
            default:     return 1'b0;
        endcase
    endfunction

    // Receiver stalls with probability 87/100 alone, 10/100 when both sides idle.
    function automatic bit dst_stall();
        int roll;
        roll = int'($urandom_range(0, 99));
        case (phase)
            PH_DST_STALL: return roll < 87;
            PH_BOTH:      return roll < 10;
            default:      return 1'b0;
        endcase
    endfunction

    // Driver: present the oldest request at the falling edge, hold it until accepted.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else if (!req_taken)
        begin
            if (!req_ch.valid && pending_q.size() > 0 && !hold_src && !src_pause())
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_q[0];
            end
        end
        else
        begin
            // accepted at the last rising edge; advance
            if (pending_q.size() > 0 && !hold_src && !src_pause())
            begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= pending_q[0];
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
            res_ch.ready <= !dst_stall();
    end

    // Monitor: predict on request acceptance, check on result acceptance.
    always @(posedge clk)
    begin
        qrv_out_t want;
        cycles    <= cycles + 1;
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            rotated_q.push_back(rotate(req_ch.data));
            void'(pending_q.pop_front());
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (rotated_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", res_ch.data);
            end
            else
            begin
                want = rotated_q.pop_front();
                if (want !== res_ch.data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("expected %p got %p", want, res_ch.data);
                end
            end
        end
    end

    // Stop the run at a generous cycle limit.
    always @(posedge clk)
    begin
        if (cycles > MAX_CYCLE)
        begin
            $display("quaternion_rotate_vector: mismatch");
            $finish;
        end
    end

    task automatic run_random(int count, phase_t ph);
        phase = ph;
        for (int i = 0; i < count; i++)
            pending_q.push_back(make_item(pick_component(), pick_component(), pick_component(),
                pick_component(), pick_component(), pick_component(), pick_component()));
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MX  = 32'h7FFF_FFFF;
        localparam logic [31:0] MN  = 32'h8000_0000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: identity, zero quaternion, 90 degree turns, non-unit, extremes.
        pending_q.push_back(make_item(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, ONE));
        pending_q.push_back(make_item(ONE, ONE, ONE, 0, 0, 0, 0));
        pending_q.push_back(make_item(MX, MN, MX, 0, 0, 0, 0));
        pending_q.push_back(make_item(ONE, 0, 0, 0, 0, 32'h0000_B505, 32'h0000_B505));
        pending_q.push_back(make_item(0, ONE, 0, 32'h0000_B505, 0, 0, 32'h0000_B505));
        pending_q.push_back(make_item(0, 0, ONE, 0, 32'h0000_B505, 0, 32'h0000_B505));
        pending_q.push_back(make_item(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 5 * ONE));
        pending_q.push_back(make_item(ONE, 0, 0, 0, 0, 3 * ONE, 0));
        pending_q.push_back(make_item(MX, MX, MX, 0, 0, 0, ONE));
        pending_q.push_back(make_item(MN, MN, MN, 0, 0, 0, MN));
        pending_q.push_back(make_item(MX, MX, MX, ONE, ONE, 0, ONE));
        pending_q.push_back(make_item(MN, MX, MN, MX, MN, MX, MN));
        pending_q.push_back(make_item(MX, MN, MX, 1, 0, 0, 0));
        pending_q.push_back(make_item(MX, MX, MN, MX, MX, MX, MX));
        pending_q.push_back(make_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      1, 1, 1, 1));
        // non-unit quarter turns: v=1, q=(1;1,0,0) and friends, then an alternating bit pattern
        pending_q.push_back(make_item(0, 1, 0, 1, 0, 0, 1));
        pending_q.push_back(make_item(0, 32'hFFFF_FFFF, 0, 1, 0, 0, 1));
        pending_q.push_back(make_item(3, 0, 0, 0, 1, 0, 1));
        pending_q.push_back(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                      32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                      32'hAAAA_AAAA));
        while (pending_q.size() != 0)
            @(posedge clk);

        run_random(350, PH_FLOW);
        run_random(200, PH_SRC_IDLE);
        // Pause the sender until every pending rotation has come back.
        hold_src = 1'b1;
        while (rotated_q.size() != 0)
            @(posedge clk);
        hold_src = 1'b0;
        run_random(200, PH_DST_STALL);
        run_random(180, PH_BOTH);

        phase = PH_FLOW;
        while (rotated_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("quaternion_rotate_vector: match");
        else
            $display("quaternion_rotate_vector: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/qrv_pkg.sv
rtl/qrv_if.sv
rtl/qrv_front.sv
rtl/qrv_datapath.sv
rtl/qrv_divider.sv
rtl/quaternion_rotate_vector.sv
rtl/qrv_checker.sv
tb/quaternion_rotate_vector_tb.sv
